// File: rtl/csgbc_pkg.sv
// Package for the charset guess byte classifier.
// Holds encoding codes, byte constants and the pair scanner range checks.
// No dependencies.
`default_nettype none

package csgbc_pkg;

  // Default message size limit and the hard ceiling of every counter.
  localparam int unsigned MaxMessageBytesDef = 4096;
  localparam int unsigned CountCeiling       = 8191;

  // Guessed encoding codes, as driven on the result port.
  typedef enum logic [2:0] {
    EncUtf8    = 3'd0,
    EncSjis    = 3'd1,
    EncLatin1  = 3'd2,
    EncGb2312  = 3'd3,
    EncBig5    = 3'd4,
    EncGbk     = 3'd5,
    EncAscii   = 3'd6,
    EncUnknown = 3'd7
  } enc_e;

  // Byte-order mark bytes.
  localparam logic [7:0] BomByte0 = 8'hEF;
  localparam logic [7:0] BomByte1 = 8'hBB;
  localparam logic [7:0] BomByte2 = 8'hBF;

  // Pair scanner indexes.
  localparam logic [1:0] ScanGb2312 = 2'd0;
  localparam logic [1:0] ScanBig5   = 2'd1;
  localparam logic [1:0] ScanGbk    = 2'd2;
  localparam int unsigned NumScan   = 3;

  function automatic logic lead_ok(input logic [1:0] s, input logic [7:0] c);
    logic ok;
    case (s)
      ScanGb2312: ok = (c >= 8'hA1) && (c <= 8'hF7);
      ScanBig5:   ok = (c >= 8'hA1) && (c <= 8'hF9);
      default:    ok = (c >= 8'h81) && (c <= 8'hFE);
    endcase
    return ok;
  endfunction

  function automatic logic trail_ok(input logic [1:0] s, input logic [7:0] c);
    logic ok;
    case (s)
      ScanGb2312: ok = (c >= 8'hA1) && (c <= 8'hFE);
      ScanBig5:   ok = ((c >= 8'h40) && (c <= 8'h7E)) || ((c >= 8'hA1) && (c <= 8'hFE));
      default:    ok = (c >= 8'h40) && (c <= 8'hFE);
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: rtl/charset_guess_byte_classifier.sv
// Charset guess byte classifier: top level, trackers, decision stage, output register.
// Depends on csgbc_pkg.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o | data_byte_i, last_byte_i
//   out      | output    | out_valid_o/out_stall_i | encoding_o
//   cfg      | input     | cfg_we_i (no wait)      | cfg_wdata_i
//
// One byte is taken every cycle unless the input is stalled. The trackers
// update in the cycle a byte is taken; on the last byte they load a snapshot
// register and clear. The decision logic runs from the snapshot into the
// output register. The input stalls only while both the snapshot and the
// output register are full and the output is stalled. Reset clears all
// trackers, the pipeline valid flags and the mode bit.
`default_nettype none

module charset_guess_byte_classifier #(
  parameter int unsigned MAX_MESSAGE_BYTES = csgbc_pkg::MaxMessageBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      encoding_o
);

  // Counters saturate at the smaller of the message limit and the ceiling.
  localparam int unsigned CountCap =
      (MAX_MESSAGE_BYTES < csgbc_pkg::CountCeiling) ? MAX_MESSAGE_BYTES
                                                    : csgbc_pkg::CountCeiling;
  localparam int unsigned CntW = $clog2(CountCap + 1);
  localparam logic [CntW-1:0] CapVal = CntW'(CountCap);

  typedef logic [CntW-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v < CapVal) ? v + cnt_t'(1) : CapVal;
  endfunction

  // ---------------------------------------------------------------- control
  logic out_adv;
  logic snap_free;
  logic in_fire;
  logic snap_load;

  logic snap_valid_q, snap_valid_d;
  logic out_valid_q, out_valid_d;
  logic assume_sjis_q;

  // Output advances when empty or taken; the snapshot frees when it can move on.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign snap_free  = !snap_valid_q || out_adv;
  assign in_stall_o = !snap_free;
  assign in_fire    = in_valid_i && snap_free;
  assign snap_load  = in_fire && last_byte_i;

  // ---------------------------------------------------------------- tracker state
  cnt_t       byte_count_q, byte_count_d;
  logic       bom_match_q, bom_match_d;
  logic       utf8_possible_q, utf8_possible_d;
  logic [1:0] utf8_remaining_q, utf8_remaining_d;
  logic       utf8_mb_seen_q, utf8_mb_seen_d;
  logic       sjis_possible_q, sjis_possible_d;
  logic       sjis_trail_q, sjis_trail_d;
  cnt_t       kata_total_q, kata_total_d;
  cnt_t       kata_run_q, kata_run_d;
  cnt_t       kata_run_max_q, kata_run_max_d;
  cnt_t       dbl_run_q, dbl_run_d;
  cnt_t       dbl_run_max_q, dbl_run_max_d;
  logic       latin1_possible_q, latin1_possible_d;
  cnt_t       latin1_high_q, latin1_high_d;
  logic [csgbc_pkg::NumScan-1:0] pair_pending_q, pair_pending_d;
  logic [csgbc_pkg::NumScan-1:0] pair_lead_q, pair_lead_d;
  logic [csgbc_pkg::NumScan-1:0] pair_failed_q, pair_failed_d;
  cnt_t       gb_pairs_q, gb_pairs_d;
  cnt_t       b5_pairs_q, b5_pairs_d;
  logic       gbk_seen_q, gbk_seen_d;
  logic       ascii_only_q, ascii_only_d;

  // ---------------------------------------------------------------- snapshot
  logic s_can_utf8_q, s_can_utf8_d;
  logic s_mb_seen_q, s_mb_seen_d;
  logic s_bom_q, s_bom_d;
  logic s_can_sjis_q, s_can_sjis_d;
  cnt_t s_krm_q, s_krm_d;
  cnt_t s_drm_q, s_drm_d;
  cnt_t s_kt_q, s_kt_d;
  logic s_latin1_q, s_latin1_d;
  cnt_t s_hs_q, s_hs_d;
  cnt_t s_bc_q, s_bc_d;
  cnt_t s_gb_q, s_gb_d;
  cnt_t s_b5_q, s_b5_d;
  logic s_can_gbk_q, s_can_gbk_d;
  logic s_ascii_q, s_ascii_d;

  // ---------------------------------------------------------------- tracker update
  always_comb begin
    logic [7:0] v;
    logic [7:0] bom_byte;
    v = data_byte_i;

    byte_count_d      = byte_count_q;
    bom_match_d       = bom_match_q;
    utf8_possible_d   = utf8_possible_q;
    utf8_remaining_d  = utf8_remaining_q;
    utf8_mb_seen_d    = utf8_mb_seen_q;
    sjis_possible_d   = sjis_possible_q;
    sjis_trail_d      = sjis_trail_q;
    kata_total_d      = kata_total_q;
    kata_run_d        = kata_run_q;
    kata_run_max_d    = kata_run_max_q;
    dbl_run_d         = dbl_run_q;
    dbl_run_max_d     = dbl_run_max_q;
    latin1_possible_d = latin1_possible_q;
    latin1_high_d     = latin1_high_q;
    pair_pending_d    = pair_pending_q;
    pair_lead_d       = pair_lead_q;
    pair_failed_d     = pair_failed_q;
    gb_pairs_d        = gb_pairs_q;
    b5_pairs_d        = b5_pairs_q;
    gbk_seen_d        = gbk_seen_q;
    ascii_only_d      = ascii_only_q;

    case (byte_count_q[1:0])
      2'd0:    bom_byte = csgbc_pkg::BomByte0;
      2'd1:    bom_byte = csgbc_pkg::BomByte1;
      default: bom_byte = csgbc_pkg::BomByte2;
    endcase

    if (in_fire) begin
      // Byte-order mark over the first three bytes.
      if (byte_count_q < cnt_t'(3) && v != bom_byte) begin
        bom_match_d = 1'b0;
      end

      // UTF-8 sequence check; freeze once ruled out.
      if (utf8_possible_q) begin
        if (utf8_remaining_q != 2'd0) begin
          if (!v[7]) utf8_possible_d = 1'b0;
          else       utf8_remaining_d = utf8_remaining_q - 2'd1;
        end else if (v[7]) begin
          if (!v[6]) begin
            utf8_possible_d = 1'b0;
          end else if (!v[5]) begin
            utf8_remaining_d = 2'd1;
            utf8_mb_seen_d   = 1'b1;
          end else if (!v[4]) begin
            utf8_remaining_d = 2'd2;
            utf8_mb_seen_d   = 1'b1;
          end else if (!v[3]) begin
            utf8_remaining_d = 2'd3;
            utf8_mb_seen_d   = 1'b1;
          end else begin
            utf8_possible_d = 1'b0;
          end
        end
      end

      // SJIS: katakana and double-byte runs.
      if (sjis_possible_q) begin
        if (sjis_trail_q) begin
          if (v < 8'h40 || v == 8'h7F || v > 8'hFC) sjis_possible_d = 1'b0;
          else                                      sjis_trail_d    = 1'b0;
        end else if (v == 8'h80 || v == 8'hA0 || v > 8'hEF) begin
          sjis_possible_d = 1'b0;
        end else if (v > 8'hA0 && v < 8'hE0) begin
          kata_total_d = sat_inc(kata_total_q);
          dbl_run_d    = '0;
          kata_run_d   = sat_inc(kata_run_q);
          if (kata_run_d > kata_run_max_q) kata_run_max_d = kata_run_d;
        end else if (v > 8'h7F) begin
          sjis_trail_d = 1'b1;
          kata_run_d   = '0;
          dbl_run_d    = sat_inc(dbl_run_q);
          if (dbl_run_d > dbl_run_max_q) dbl_run_max_d = dbl_run_d;
        end else begin
          kata_run_d = '0;
          dbl_run_d  = '0;
        end
      end

      // ISO-8859-1: C1 controls rule it out; count high symbols.
      if (latin1_possible_q) begin
        if (v > 8'h7F && v < 8'hA0) begin
          latin1_possible_d = 1'b0;
        end else if (v > 8'h9F && (v < 8'hC0 || v == 8'hD7 || v == 8'hF7)) begin
          latin1_high_d = sat_inc(latin1_high_q);
        end
      end

      // Lead/trail pair scanners; the byte after any high byte is its trail.
      for (int s = 0; s < csgbc_pkg::NumScan; s++) begin
        if (pair_pending_q[s]) begin
          pair_pending_d[s] = 1'b0;
          if (pair_lead_q[s] && csgbc_pkg::trail_ok(2'(s), v)) begin
            if (2'(s) == csgbc_pkg::ScanGb2312)    gb_pairs_d = sat_inc(gb_pairs_q);
            else if (2'(s) == csgbc_pkg::ScanBig5) b5_pairs_d = sat_inc(b5_pairs_q);
            else                                   gbk_seen_d = 1'b1;
          end else begin
            pair_failed_d[s] = 1'b1;
          end
        end else if (v[7]) begin
          pair_pending_d[s] = 1'b1;
          pair_lead_d[s]    = csgbc_pkg::lead_ok(2'(s), v);
        end
      end

      if (v[7]) ascii_only_d = 1'b0;
      byte_count_d = sat_inc(byte_count_q);
    end

    // Snapshot of the decision inputs after this byte.
    s_can_utf8_d = utf8_possible_d && (utf8_remaining_d == 2'd0);
    s_mb_seen_d  = utf8_mb_seen_d;
    s_bom_d      = bom_match_d && (byte_count_d > cnt_t'(3));
    s_can_sjis_d = sjis_possible_d && !sjis_trail_d;
    s_krm_d      = kata_run_max_d;
    s_drm_d      = dbl_run_max_d;
    s_kt_d       = kata_total_d;
    s_latin1_d   = latin1_possible_d;
    s_hs_d       = latin1_high_d;
    s_bc_d       = byte_count_d;
    // An open lead at the end counts as a failed pair.
    s_gb_d       = (pair_failed_d[csgbc_pkg::ScanGb2312] ||
                    pair_pending_d[csgbc_pkg::ScanGb2312]) ? '0 : gb_pairs_d;
    s_b5_d       = (pair_failed_d[csgbc_pkg::ScanBig5] ||
                    pair_pending_d[csgbc_pkg::ScanBig5]) ? '0 : b5_pairs_d;
    s_can_gbk_d  = !(pair_failed_d[csgbc_pkg::ScanGbk] ||
                     pair_pending_d[csgbc_pkg::ScanGbk]) && gbk_seen_d;
    s_ascii_d    = ascii_only_d;

    // Clear for the next message after the last byte.
    if (snap_load) begin
      byte_count_d      = '0;
      bom_match_d       = 1'b1;
      utf8_possible_d   = 1'b1;
      utf8_remaining_d  = 2'd0;
      utf8_mb_seen_d    = 1'b0;
      sjis_possible_d   = 1'b1;
      sjis_trail_d      = 1'b0;
      kata_total_d      = '0;
      kata_run_d        = '0;
      kata_run_max_d    = '0;
      dbl_run_d         = '0;
      dbl_run_max_d     = '0;
      latin1_possible_d = 1'b1;
      latin1_high_d     = '0;
      pair_pending_d    = '0;
      pair_lead_d       = '0;
      pair_failed_d     = '0;
      gb_pairs_d        = '0;
      b5_pairs_d        = '0;
      gbk_seen_d        = 1'b0;
      ascii_only_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q      <= '0;
      bom_match_q       <= 1'b1;
      utf8_possible_q   <= 1'b1;
      utf8_remaining_q  <= 2'd0;
      utf8_mb_seen_q    <= 1'b0;
      sjis_possible_q   <= 1'b1;
      sjis_trail_q      <= 1'b0;
      kata_total_q      <= '0;
      kata_run_q        <= '0;
      kata_run_max_q    <= '0;
      dbl_run_q         <= '0;
      dbl_run_max_q     <= '0;
      latin1_possible_q <= 1'b1;
      latin1_high_q     <= '0;
      pair_pending_q    <= '0;
      pair_lead_q       <= '0;
      pair_failed_q     <= '0;
      gb_pairs_q        <= '0;
      b5_pairs_q        <= '0;
      gbk_seen_q        <= 1'b0;
      ascii_only_q      <= 1'b1;
    end else begin
      byte_count_q      <= byte_count_d;
      bom_match_q       <= bom_match_d;
      utf8_possible_q   <= utf8_possible_d;
      utf8_remaining_q  <= utf8_remaining_d;
      utf8_mb_seen_q    <= utf8_mb_seen_d;
      sjis_possible_q   <= sjis_possible_d;
      sjis_trail_q      <= sjis_trail_d;
      kata_total_q      <= kata_total_d;
      kata_run_q        <= kata_run_d;
      kata_run_max_q    <= kata_run_max_d;
      dbl_run_q         <= dbl_run_d;
      dbl_run_max_q     <= dbl_run_max_d;
      latin1_possible_q <= latin1_possible_d;
      latin1_high_q     <= latin1_high_d;
      pair_pending_q    <= pair_pending_d;
      pair_lead_q       <= pair_lead_d;
      pair_failed_q     <= pair_failed_d;
      gb_pairs_q        <= gb_pairs_d;
      b5_pairs_q        <= b5_pairs_d;
      gbk_seen_q        <= gbk_seen_d;
      ascii_only_q      <= ascii_only_d;
    end
  end

  // Snapshot payload: load on the last byte, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      s_can_utf8_q <= s_can_utf8_d;
      s_mb_seen_q  <= s_mb_seen_d;
      s_bom_q      <= s_bom_d;
      s_can_sjis_q <= s_can_sjis_d;
      s_krm_q      <= s_krm_d;
      s_drm_q      <= s_drm_d;
      s_kt_q       <= s_kt_d;
      s_latin1_q   <= s_latin1_d;
      s_hs_q       <= s_hs_d;
      s_bc_q       <= s_bc_d;
      s_gb_q       <= s_gb_d;
      s_b5_q       <= s_b5_d;
      s_can_gbk_q  <= s_can_gbk_d;
      s_ascii_q    <= s_ascii_d;
    end
  end

  // ---------------------------------------------------------------- decision
  cnt_t                cw;
  logic [CntW:0]       cb;
  logic [CntW+1:0]     jb;
  logic [CntW+3:0]     hs10;
  logic                sjis_pref;
  logic                can_gb;
  logic                can_b5;
  logic                long_runs;
  logic                latin_hint;
  csgbc_pkg::enc_e     enc_d;
  logic [2:0]          encoding_q;

  assign cw         = (s_gb_q > s_b5_q) ? s_gb_q : s_b5_q;
  assign cb         = {cw, 1'b0};
  assign jb         = {2'b00, s_krm_q} + {1'b0, s_drm_q, 1'b0};
  assign sjis_pref  = ({1'b0, cb} < jb) || (({1'b0, cb} == jb) && (cw < s_kt_q));
  assign can_gb     = (s_gb_q != '0);
  assign can_b5     = (s_b5_q != '0);
  assign long_runs  = assume_sjis_q || (s_krm_q >= cnt_t'(3)) || (s_drm_q >= cnt_t'(3));
  // High symbols times ten against the byte count.
  assign hs10       = {1'b0, s_hs_q, 3'b000} + {3'b000, s_hs_q, 1'b0};
  assign latin_hint = ((s_krm_q == cnt_t'(2)) && (s_kt_q == cnt_t'(2))) ||
                      (hs10 >= {4'b0000, s_bc_q});

  always_comb begin
    logic done;
    done  = 1'b0;
    enc_d = csgbc_pkg::EncUnknown;
    if (s_can_utf8_q && (s_bom_q || s_mb_seen_q)) begin
      enc_d = csgbc_pkg::EncUtf8;
      done  = 1'b1;
    end else if (s_can_sjis_q && long_runs && sjis_pref) begin
      enc_d = csgbc_pkg::EncSjis;
      done  = 1'b1;
    end else if (s_latin1_q && s_can_sjis_q) begin
      if (latin_hint) begin
        if (sjis_pref) begin
          enc_d = csgbc_pkg::EncSjis;
          done  = 1'b1;
        end
      end else if (cb == '0 && !can_gb && !can_b5) begin
        enc_d = csgbc_pkg::EncLatin1;
        done  = 1'b1;
      end
    end
    // Fall through to the plain preference order.
    if (!done) begin
      if (can_gb)            enc_d = csgbc_pkg::EncGb2312;
      else if (can_b5)       enc_d = csgbc_pkg::EncBig5;
      else if (s_can_sjis_q) enc_d = csgbc_pkg::EncSjis;
      else if (s_can_gbk_q)  enc_d = csgbc_pkg::EncGbk;
      else if (s_latin1_q)   enc_d = csgbc_pkg::EncLatin1;
      else if (s_can_utf8_q) enc_d = csgbc_pkg::EncUtf8;
      else if (s_ascii_q)    enc_d = csgbc_pkg::EncAscii;
      else                   enc_d = csgbc_pkg::EncUnknown;
    end
  end

  // ---------------------------------------------------------------- pipeline flags
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (snap_load)                    snap_valid_d = 1'b1;
    else if (snap_valid_q && out_adv) snap_valid_d = 1'b0;
    out_valid_d = out_adv ? snap_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      assume_sjis_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) assume_sjis_q <= cfg_wdata_i;
    end
  end

  // Result payload: advance from the snapshot, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (out_adv && snap_valid_q) encoding_q <= enc_d;
  end

  assign out_valid_o = out_valid_q;
  assign encoding_o  = encoding_q;

  // ---------------------------------------------------------------- assertions
  a_kata_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kata_run_q <= kata_run_max_q) && (kata_run_max_q <= kata_total_q))
    else $error("katakana run exceeds its maximum or total");

  a_dbl_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbl_run_q <= dbl_run_max_q)
    else $error("double-byte run exceeds its maximum");

  a_ascii_keeps_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ascii_only_q |-> (latin1_possible_q && utf8_possible_q && sjis_possible_q))
    else $error("tracker ruled out on a pure ASCII message");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_load |=> (snap_valid_q && (byte_count_q == '0) && (pair_pending_q == '0)))
    else $error("last byte did not load the snapshot and clear the trackers");

endmodule

`default_nettype wire
